@@ hdl/lcs_pkg.sv @@
// Shared types and constants for the link connect supervisor.
`default_nettype none
package lcs_pkg;

   // Supervisor modes
   localparam logic [2:0] MODE_CONNECT = 3'd0;
   localparam logic [2:0] MODE_NORMAL  = 3'd1;
   localparam logic [2:0] MODE_REPORT  = 3'd2;
   localparam logic [2:0] MODE_WAIT    = 3'd3;
   localparam logic [2:0] MODE_DISC    = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_RETRY_PERIOD  = 2'd0;
   localparam logic [1:0] CSR_MAX_ATTEMPTS  = 2'd1;
   localparam logic [1:0] CSR_WAIT_TIMEOUT  = 2'd2;
   localparam logic [1:0] CSR_REPORT_PERIOD = 2'd3;

   localparam int PERIOD_BITS = 24;
   localparam int LIMIT_BITS  = 8;
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [PERIOD_BITS-1:0] RETRY_PERIOD_RST  = 24'd5000;
   localparam logic [LIMIT_BITS-1:0]  MAX_ATTEMPTS_RST  = 8'd3;
   localparam logic [PERIOD_BITS-1:0] WAIT_TIMEOUT_RST  = 24'd10000;
   localparam logic [PERIOD_BITS-1:0] REPORT_PERIOD_RST = 24'd60000;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] retry_period_ticks;
      logic [LIMIT_BITS-1:0]  max_attempts;
      logic [PERIOD_BITS-1:0] wait_timeout_ticks;
      logic [PERIOD_BITS-1:0] report_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic response_seen;
      logic report_built;
      logic report_due;
      logic send_ok;
      logic connect_ok;
   } req_type;

   typedef struct packed {
      logic       response_timeout;
      logic       report_requested;
      logic       message_popped;
      logic       link_closed;
      logic       send_tried;
      logic       connect_tried;
      logic [2:0] mode_now;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/link_connect_supervisor.sv @@
// Top level of the link connect supervisor.
`default_nettype none
// Link connect supervisor, polled once per tick. Each req transaction carries the
// outcomes of this poll's outside actions; the block advances its mode machine
// (connecting, normal, send report, wait response, disconnected) and returns one rsp
// transaction with the new mode and the actions taken. Throughput is one
// transaction per clock while rsp is not backpressured: a transaction is held in the
// input register, the step logic runs between that register and the result register,
// and the next transaction follows right behind it. rsp_tvalid rises once the
// transaction has moved from the input register into the result register.
// Backpressure on rsp stalls the result register and then the input
// register. Configuration is written through csr_we/csr_addr/csr_wdata and should
// only change while no transaction is in flight. Disconnected is terminal until reset.
module link_connect_supervisor
   import lcs_pkg::*;
#(
   parameter int TIMER_BITS = 24,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   // [0] connect_ok, [1] send_ok, [2] report_due, [3] report_built,
   // [4] response_seen, [7:5] zero
   input  wire logic [7:0]               req_tdata,
   // response channel
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [2:0] mode_now, [3] connect_tried, [4] send_tried, [5] link_closed,
   // [6] message_popped, [7] report_requested, [8] response_timeout, [15:9] zero
   output      logic [15:0]              rsp_tdata,
   // configuration write port
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [PERIOD_BITS-1:0]   csr_wdata
);

   cfg_type cfg;

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // result stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   rsp_type step_result;
   logic    advance;   // input stage moves into result stage (one poll executes)
   logic    req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take  = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   lcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcs_core #(
      .TIMER_BITS (TIMER_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_type'(req_tdata[4:0]);
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_data_ff};

`ifndef SYNTH
   // a waiting input transaction always lands in an empty result stage
   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("input transaction not moved to result stage");

   // disconnected is terminal: next result is disconnected too
   a_disc_terminal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && out_data_ff.mode_now == MODE_DISC
      |=> !rsp_tvalid || out_data_ff.mode_now == MODE_DISC)
      else $error("left disconnected mode");

   // no action flags once disconnected
   a_disc_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_data_ff.mode_now == MODE_DISC |-> rsp_tdata[8:3] == '0)
      else $error("action flagged in disconnected mode");

   // a dropped link follows a send and returns to connecting
   a_close_path : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_data_ff.link_closed
      |-> out_data_ff.send_tried && out_data_ff.mode_now == MODE_CONNECT)
      else $error("link close without send or wrong mode");
`endif

endmodule
`default_nettype wire

@@ hdl/lcs_csr.sv @@
// Configuration register file for the link connect supervisor.
`default_nettype none
module lcs_csr
   import lcs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [PERIOD_BITS-1:0]   csr_wdata,
   output cfg_type                       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RETRY_PERIOD:  cfg_in.retry_period_ticks  = csr_wdata;
            CSR_MAX_ATTEMPTS:  cfg_in.max_attempts        = csr_wdata[LIMIT_BITS-1:0];
            CSR_WAIT_TIMEOUT:  cfg_in.wait_timeout_ticks  = csr_wdata;
            CSR_REPORT_PERIOD: cfg_in.report_period_ticks = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_period_ticks  <= RETRY_PERIOD_RST;
         cfg_ff.max_attempts        <= MAX_ATTEMPTS_RST;
         cfg_ff.wait_timeout_ticks  <= WAIT_TIMEOUT_RST;
         cfg_ff.report_period_ticks <= REPORT_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/lcs_core.sv @@
// Supervisor state (mode, tick timer, attempt count) and per-poll step logic.
`default_nettype none
module lcs_core
   import lcs_pkg::*;
#(
   parameter int TIMER_BITS = 24,
   parameter int COUNT_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step_en,
   input  req_type   item,
   input  cfg_type   cfg,
   output rsp_type   result
);

   localparam int TW = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;
   localparam int CW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [2:0]            mode_ff, mode_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [TIMER_BITS-1:0] timer_inc;
   logic [TW-1:0]         timer_ext;
   logic [CW-1:0]         count_ext;
   logic [CW-1:0]         limit_ext;
   logic                  retry_due, report_elapsed, wait_elapsed, give_up;

   assign timer_inc = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + 1'b1;
   assign timer_ext = TW'(timer_inc);
   assign count_ext = CW'(count_ff);
   assign limit_ext = CW'(cfg.max_attempts);

   assign retry_due      = timer_ext >= TW'(cfg.retry_period_ticks);
   assign report_elapsed = timer_ext >= TW'(cfg.report_period_ticks);
   assign wait_elapsed   = timer_ext >= TW'(cfg.wait_timeout_ticks);
   assign give_up        = (cfg.max_attempts != '0) && (count_ext >= limit_ext);

   always_comb begin
      mode_in  = mode_ff;
      timer_in = timer_inc;
      count_in = count_ff;
      result   = '0;
      unique case (mode_ff)
         MODE_CONNECT: begin
            if (count_ff == '0) begin
               result.connect_tried = 1'b1;
               count_in = COUNT_BITS'(1);
               timer_in = '0;
               if (item.connect_ok) mode_in = MODE_NORMAL;
            end else if (give_up) begin
               mode_in = MODE_DISC;
            end else if (retry_due) begin
               result.connect_tried = 1'b1;
               timer_in = '0;
               if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
               if (item.connect_ok) mode_in = MODE_NORMAL;
            end
         end
         MODE_NORMAL: begin
            result.message_popped = 1'b1;
            result.send_tried     = 1'b1;
            if (!item.send_ok) begin
               result.link_closed = 1'b1;
               mode_in  = MODE_CONNECT;
               count_in = '0;
            end else if (report_elapsed) begin
               timer_in = '0;
               if (item.report_due) mode_in = MODE_REPORT;
            end
         end
         MODE_REPORT: begin
            result.report_requested = 1'b1;
            if (item.report_built) begin
               result.send_tried = 1'b1;
               if (item.send_ok) begin
                  mode_in  = MODE_WAIT;
                  timer_in = '0;
               end else begin
                  result.link_closed = 1'b1;
                  mode_in  = MODE_CONNECT;
                  count_in = '0;
               end
            end
         end
         MODE_WAIT: begin
            if (item.response_seen) begin
               mode_in  = MODE_NORMAL;
               timer_in = '0;
            end else if (wait_elapsed) begin
               result.response_timeout = 1'b1;
               mode_in  = MODE_NORMAL;
               timer_in = '0;
            end
         end
         default: begin
            mode_in = MODE_DISC;
         end
      endcase
      result.mode_now = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CONNECT;
         timer_ff <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ bench/link_connect_supervisor_tb.sv @@
// Self-checking testbench for the link connect supervisor: directed script, then random phases.
`timescale 1ns / 100ps
module link_connect_supervisor_tb;
   import lcs_pkg::*;

   // Saturation points of the supervisor's timer and attempt counter
   localparam logic [PERIOD_BITS-1:0] TIMER_TOP = '1;
   localparam logic [LIMIT_BITS-1:0]  COUNT_TOP = '1;

   // One register setting plus the shape of the polls that run under it
   typedef struct {
      int unsigned retry;
      int unsigned limit;
      int unsigned wait_ticks;
      int unsigned report;
      int unsigned polls;
      int unsigned cok_pct;      // chance that a connect attempt succeeds
      int unsigned sok_pct;      // chance that a send succeeds
      bit          noise;        // every input bit a coin toss
      bit          steady;       // no idle cycles on either side
   } setting_plan;

   // A row of the opening script: either a register write or a poll
   typedef struct {
      bit                     is_write;
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [PERIOD_BITS-1:0] value;
      req_type                poll;
      bit                     typed;    // want holds a hand-written status
      rsp_type                want;
   } script_row;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [15:0]              rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [PERIOD_BITS-1:0]   csr_wdata = '0;

   // Shadow of the supervisor: its registers and state as the bench believes them
   cfg_type                link_cfg;
   logic [2:0]             lnk_mode;
   logic [PERIOD_BITS-1:0] lnk_timer;
   logic [LIMIT_BITS-1:0]  lnk_tries;

   rsp_type     pending_status[$];   // statuses still owed by the block, oldest first
   script_row   opening[$];
   setting_plan plans[$];
   bit          steady = 1'b0;
   int          mismatches = 0;
   int          polls_sent = 0;
   int          statuses_checked = 0;
   int          mode_hits[5] = '{0, 0, 0, 0, 0};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   link_connect_supervisor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // One poll of the supervisor: the timer ticks, then the current mode acts.
   task automatic advance_link(input req_type p, output rsp_type r);
      r = '0;
      if (lnk_timer != TIMER_TOP) lnk_timer++;
      case (lnk_mode)
         MODE_CONNECT: begin
            if (lnk_tries == '0) begin
               // first attempt goes out at once and starts the retry period
               r.connect_tried = 1'b1;
               lnk_tries = 8'd1;
               lnk_timer = '0;
               if (p.connect_ok) lnk_mode = MODE_NORMAL;
            end else if (link_cfg.max_attempts != 0 && lnk_tries >= link_cfg.max_attempts) begin
               lnk_mode = MODE_DISC;
            end else if (lnk_timer >= link_cfg.retry_period_ticks) begin
               lnk_timer = '0;
               if (lnk_tries != COUNT_TOP) lnk_tries++;
               r.connect_tried = 1'b1;
               if (p.connect_ok) lnk_mode = MODE_NORMAL;
            end
         end
         MODE_NORMAL: begin
            r.message_popped = 1'b1;
            r.send_tried = 1'b1;
            if (!p.send_ok) begin
               r.link_closed = 1'b1;
               lnk_mode = MODE_CONNECT;
               lnk_tries = '0;
            end else if (lnk_timer >= link_cfg.report_period_ticks) begin
               lnk_timer = '0;
               if (p.report_due) lnk_mode = MODE_REPORT;
            end
         end
         MODE_REPORT: begin
            r.report_requested = 1'b1;
            // an unbuilt report just retries on the next poll
            if (p.report_built) begin
               r.send_tried = 1'b1;
               if (p.send_ok) begin
                  lnk_mode = MODE_WAIT;
                  lnk_timer = '0;
               end else begin
                  r.link_closed = 1'b1;
                  lnk_mode = MODE_CONNECT;
                  lnk_tries = '0;
               end
            end
         end
         MODE_WAIT: begin
            // a response wins over a timeout landing on the same poll
            if (p.response_seen) begin
               lnk_mode = MODE_NORMAL;
               lnk_timer = '0;
            end else if (lnk_timer >= link_cfg.wait_timeout_ticks) begin
               r.response_timeout = 1'b1;
               lnk_mode = MODE_NORMAL;
               lnk_timer = '0;
            end
         end
         default: lnk_mode = MODE_DISC;   // disconnected is terminal
      endcase
      r.mode_now = lnk_mode;
   endtask

   function automatic void stage_write(logic [CSR_ADDR_BITS-1:0] addr,
                                       logic [PERIOD_BITS-1:0] value);
      script_row row;
      row = '{1'b1, addr, value, req_type'('0), 1'b0, rsp_type'('0)};
      opening.push_back(row);
   endfunction

   // bits are {response_seen, report_built, report_due, send_ok, connect_ok}
   function automatic void stage_poll(logic [4:0] bits, bit typed = 1'b0,
                                      rsp_type want = '0);
      script_row row;
      row = '{1'b0, '0, '0, req_type'(bits), typed, want};
      opening.push_back(row);
   endfunction

   function automatic req_type draw_poll(setting_plan pl);
      req_type p;
      if (pl.noise) return req_type'(5'($urandom_range(31)));
      p.connect_ok    = $urandom_range(99) < pl.cok_pct;
      p.send_ok       = $urandom_range(99) < pl.sok_pct;
      p.report_due    = $urandom_range(99) < 60;
      p.report_built  = $urandom_range(99) < 70;
      p.response_seen = $urandom_range(99) < 25;
      return p;
   endfunction

   // Offer one poll, hold it until taken, then log what the block owes for it.
   // tvalid is not dropped after acceptance; the next call or the drain decides.
   task automatic send_poll(input req_type p, input bit typed, input rsp_type want);
      rsp_type forecast;
      while (!steady && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_link(p, forecast);
      pending_status.push_back(typed ? want : forecast);
      polls_sent++;
   endtask

   // Registers only change with nothing in flight: drain, then let the
   // two-stage pipe settle.
   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr_we is left high; the caller lowers it once the group of writes is done
   task automatic put_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                          input logic [PERIOD_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_RETRY_PERIOD:  link_cfg.retry_period_ticks  = value;
         CSR_MAX_ATTEMPTS:  link_cfg.max_attempts        = value[LIMIT_BITS-1:0];
         CSR_WAIT_TIMEOUT:  link_cfg.wait_timeout_ticks  = value;
         CSR_REPORT_PERIOD: link_cfg.report_period_ticks = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_phase(input setting_plan pl);
      logic [31:0] junk;
      junk = $urandom;
      await_idle();
      put_reg(CSR_RETRY_PERIOD, 24'(pl.retry));
      // upper bits of the attempt limit write are don't-care, so load them with junk
      put_reg(CSR_MAX_ATTEMPTS, {junk[15:0], 8'(pl.limit)});
      put_reg(CSR_WAIT_TIMEOUT, 24'(pl.wait_ticks));
      put_reg(CSR_REPORT_PERIOD, 24'(pl.report));
      csr_we <= 1'b0;
      steady = pl.steady;
   endtask

   function automatic int field_miss(string name, logic [2:0] want, logic [2:0] got);
      if (got === want) return 0;
      $display("%0t ns: status %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   // Result side: random backpressure, except during steady stretches
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 36);

   // Status checker: every accepted status against the oldest one owed
   always @(posedge clock) begin
      rsp_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_type'(rsp_tdata[8:0]);
         if (pending_status.size() == 0) begin
            mismatches++;
            $display("%0t ns: status transaction %h with none expected", $time, rsp_tdata);
         end else begin
            want = pending_status.pop_front();
            mismatches += field_miss("mode_now", want.mode_now, seen.mode_now);
            mismatches += field_miss("connect_tried", want.connect_tried, seen.connect_tried);
            mismatches += field_miss("send_tried", want.send_tried, seen.send_tried);
            mismatches += field_miss("link_closed", want.link_closed, seen.link_closed);
            mismatches += field_miss("message_popped", want.message_popped,
                                     seen.message_popped);
            mismatches += field_miss("report_requested", want.report_requested,
                                     seen.report_requested);
            mismatches += field_miss("response_timeout", want.response_timeout,
                                     seen.response_timeout);
            if (want.mode_now <= MODE_DISC) mode_hits[want.mode_now]++;
            statuses_checked++;
         end
      end
   end

   // Main stimulus
   initial begin
      setting_plan pl;
      req_type     p;
      bit          prev_write;
      logic [31:0] noise_bits;

      link_cfg = '{RETRY_PERIOD_RST, MAX_ATTEMPTS_RST, WAIT_TIMEOUT_RST, REPORT_PERIOD_RST};
      lnk_mode  = MODE_CONNECT;
      lnk_timer = '0;
      lnk_tries = '0;

      // Opening script. Poll legend: {response_seen, report_built, report_due,
      // send_ok, connect_ok}. Status legend: {timeout, report_req, popped,
      // closed, send_tried, connect_tried, mode}.
      // Straight out of reset: the first attempt is immediate and fails
      stage_poll(5'b00000, 1'b1, rsp_type'({6'b000001, MODE_CONNECT}));
      // default retry period is long, so nothing happens on the next poll
      stage_poll(5'b11110, 1'b1, rsp_type'({6'b000000, MODE_CONNECT}));
      // short periods: retry and report can fire on the next poll, the wait times out on the third
      stage_write(CSR_RETRY_PERIOD, 24'd1);
      stage_write(CSR_MAX_ATTEMPTS, 24'd3);
      stage_write(CSR_WAIT_TIMEOUT, 24'd3);
      stage_write(CSR_REPORT_PERIOD, 24'd1);
      stage_poll(5'b00000);   // paced retry fails
      stage_poll(5'b00001);   // paced retry connects
      stage_poll(5'b11100);   // send fails in normal: link dropped
      stage_poll(5'b00001);   // fresh first attempt connects
      stage_poll(5'b10010);   // report period elapses, nothing due
      stage_poll(5'b00110);   // report due
      stage_poll(5'b00000);   // report not built: stay and retry
      stage_poll(5'b01000);   // report built but send fails: link dropped
      stage_poll(5'b00001);
      stage_poll(5'b00110);
      stage_poll(5'b01010);   // report sent, start waiting
      stage_poll(5'b00000);
      stage_poll(5'b10000);   // response arrives
      stage_poll(5'b00110);
      stage_poll(5'b01010);
      stage_poll(5'b00000);
      stage_poll(5'b00000);
      stage_poll(5'b00000);   // wait timeout
      stage_poll(5'b11111);   // all inputs high through normal, report, wait
      stage_poll(5'b11111);
      stage_poll(5'b11111);

      // Random phases; attempt limits stay unlimited, high, or (a limit of 1) paired
      // with sure connects, so the terminal disconnect is not hit before the closing phase
      plans.push_back('{3, 0, 4, 2, 200, 0, 0, 1'b1, 1'b0});
      plans.push_back('{1, 255, 1, 1, 220, 85, 92, 1'b0, 1'b1});
      plans.push_back('{24'hFFFFFF, 12, 6, 5, 150, 90, 95, 1'b0, 1'b0});
      plans.push_back('{2, 0, 24'hFFFFFF, 3, 200, 80, 95, 1'b0, 1'b0});
      plans.push_back('{4, 1, 5, 24'hFFFFFF, 150, 100, 90, 1'b0, 1'b0});
      repeat (4) begin
         pl = '{$urandom_range(1, 9), 0, $urandom_range(1, 12), $urandom_range(1, 12),
                100, 80, 92, 1'b0, 1'b0};
         if ($urandom_range(1)) pl.limit = $urandom_range(8, 40);
         plans.push_back(pl);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      prev_write = 1'b0;
      foreach (opening[i]) begin
         if (opening[i].is_write) begin
            if (!prev_write) await_idle();
            put_reg(opening[i].addr, opening[i].value);
         end else begin
            if (prev_write) csr_we <= 1'b0;
            send_poll(opening[i].poll, opening[i].typed, opening[i].want);
         end
         prev_write = opening[i].is_write;
      end

      foreach (plans[i]) begin
         program_phase(plans[i]);
         repeat (plans[i].polls) send_poll(draw_poll(plans[i]), 1'b0, '0);
      end

      // Closing: unlimited retries with every connect failing drives the
      // attempt counter into saturation; a limit of 255 then gives up, and
      // disconnected must hold through whatever follows.
      program_phase('{1, 0, 2, 1, 0, 0, 0, 1'b1, 1'b0});
      repeat (300) begin
         noise_bits = $urandom;
         p = req_type'(noise_bits[4:0]);
         p.connect_ok   = 1'b0;
         p.send_ok      = 1'b0;
         p.report_built = 1'b1;
         send_poll(p, 1'b0, '0);
      end
      await_idle();
      put_reg(CSR_MAX_ATTEMPTS, 24'd255);
      csr_we <= 1'b0;
      repeat (16) send_poll(draw_poll(plans[0]), 1'b0, '0);
      program_phase('{1, 0, 1, 1, 0, 0, 0, 1'b1, 1'b0});
      repeat (8) send_poll(draw_poll(plans[0]), 1'b0, '0);

      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d polls over %0d register settings, %0d statuses checked",
               polls_sent, plans.size() + 4, statuses_checked);
      $display("Status modes seen: connect %0d, normal %0d, report %0d, wait %0d, disc %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (about 1700 polls under random stalls)
   initial begin
      #3_600_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
